/* rtl/video_port_register_interface_macros.svh */
// Assertion helpers, clocked on clk and disabled during rst.
`ifndef VIDEO_PORT_REGISTER_INTERFACE_MACROS_SVH
`define VIDEO_PORT_REGISTER_INTERFACE_MACROS_SVH
`ifndef SYNTHESIS
`define VPRI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define VPRI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define VPRI_ASSERT_IMP(lbl, ante, cons)
`define VPRI_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/vpri_pkg.sv */
package vpri_pkg;

  localparam int VPRI_VRAM_ADDR_BITS   = 16;
  localparam int VPRI_PALETTE_ENTRIES  = 256;

  localparam logic [31:0] PALETTE_RESET_VALUE = 32'h0000_00FF;

  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 10;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VBLANK_LINE = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_READY_LINE  = 1'b1;

  localparam logic [9:0] VBLANK_LINE_RESET = 10'd192;
  localparam logic [9:0] READY_LINE_RESET  = 10'd192;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [3:0] PORT_CTRL    = 4'd0;
  localparam logic [3:0] PORT_DATA    = 4'd1;
  localparam logic [3:0] PORT_STATUS  = 4'd2;
  localparam logic [3:0] PORT_PAL_IDX = 4'd3;
  localparam logic [3:0] PORT_PAL_R   = 4'd4;
  localparam logic [3:0] PORT_PAL_A   = 4'd7;
  localparam logic [3:0] PORT_SCROLL0 = 4'd8;
  localparam logic [3:0] PORT_SCROLL3 = 4'd11;
  localparam logic [3:0] PORT_BANK0   = 4'd12;
  localparam logic [3:0] PORT_BANK1   = 4'd13;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } status_t;

endpackage

/* rtl/vpri_item_if.sv */
interface vpri_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [3:0] port;
  logic [7:0] write_data;
  logic [9:0] scanline;

  modport source (output valid, opcode, port, write_data, scanline, input ready);
  modport sink (input valid, opcode, port, write_data, scanline, output ready);
endinterface

/* rtl/vpri_result_if.sv */
interface vpri_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [15:0] cur_pointer;
  logic [7:0]  control_value;
  logic        frame_done;

  modport source (output valid, read_data, cur_pointer, control_value, frame_done,
                  input ready);
  modport sink (input valid, read_data, cur_pointer, control_value, frame_done,
                output ready);
endinterface

/* rtl/vpri_ctrl.sv */
`include "video_port_register_interface_macros.svh"

module vpri_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  vpri_pkg::status_t status,
  output vpri_pkg::cmd_t    cmd
);
  import vpri_pkg::*;

  state_t state, state_next;
  logic   accept;

  assign accept = item_valid && item_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (status.clear_last) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_EXEC;
      ST_EXEC:  state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        item_ready = !out_valid || out_ready;
        cmd.accept = item_valid && (!out_valid || out_ready);
      end
      ST_EXEC:  cmd.exec = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `VPRI_ASSERT_IMP(a_no_accept_in_clear, state == ST_CLEAR, !item_ready)
  `VPRI_ASSERT_IMP(a_accept_slot_free, accept, !out_valid || out_ready)
  `VPRI_ASSERT_NXT(a_accept_then_exec, accept, state == ST_EXEC)
  `VPRI_ASSERT_NXT(a_exec_gives_result, cmd.exec, out_valid)

endmodule

/* rtl/vpri_datapath.sv */
module vpri_datapath #(
  parameter int VRAM_ADDR_BITS  = vpri_pkg::VPRI_VRAM_ADDR_BITS,
  parameter int PALETTE_ENTRIES = vpri_pkg::VPRI_PALETTE_ENTRIES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  vpri_pkg::cmd_t                      cmd,
  output vpri_pkg::status_t                   status,
  input  logic [1:0]                          opcode,
  input  logic [3:0]                          port,
  input  logic [7:0]                          write_data,
  input  logic [9:0]                          scanline,
  input  logic                                cfg_we,
  input  logic [vpri_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [vpri_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output logic [7:0]                          read_data,
  output logic [15:0]                         cur_pointer,
  output logic [7:0]                          control_value,
  output logic                                frame_done
);
  import vpri_pkg::*;

  localparam int VRAM_DEPTH   = 1 << VRAM_ADDR_BITS;
  localparam int PAL_IDX_BITS = $clog2(PALETTE_ENTRIES);
  localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

  logic [7:0]  vram [VRAM_DEPTH];
  logic [31:0] pal_mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] pal_valid;

  logic [VRAM_ADDR_BITS-1:0] clear_addr;

  logic [15:0] ptr, ptr_next;
  logic [7:0]  low_byte, low_byte_next;
  logic        pending, pending_next;
  logic [7:0]  pal_sel, pal_sel_next;
  logic [7:0]  ctrl_byte, ctrl_byte_next;
  logic [7:0]  scroll [4];
  logic [1:0]  bank;
  logic        vblank, vblank_next;
  logic        ready, ready_next;
  logic [9:0]  vblank_line, ready_line;

  logic [1:0]  op_q;
  logic [3:0]  port_q;
  logic [7:0]  wdata_q;
  logic [9:0]  line_q;
  logic [7:0]  vram_q;
  logic [31:0] pal_q;
  logic        pal_vq;

  logic [VRAM_ADDR_BITS-1:0] vram_addr;
  logic [PAL_IDX_BITS-1:0]   pal_idx;
  logic [31:0] pal_word, pal_merged;
  logic [7:0]  lane_byte;
  logic        pal_in_range;
  logic [7:0]  rd;
  logic        vram_we, pal_we, scroll_we, bank_we;

  assign vram_addr    = ptr[VRAM_ADDR_BITS-1:0];
  assign pal_idx      = pal_sel[PAL_IDX_BITS-1:0];
  assign pal_in_range = {1'b0, pal_sel} < PAL_LIMIT;
  assign pal_word     = pal_vq ? pal_q : PALETTE_RESET_VALUE;
  assign status.clear_last = &clear_addr;

  always_comb begin
    pal_merged = pal_word;
    case (port_q[1:0])
      2'd0: begin
        lane_byte          = pal_word[31:24];
        pal_merged[31:24]  = wdata_q;
      end
      2'd1: begin
        lane_byte          = pal_word[23:16];
        pal_merged[23:16]  = wdata_q;
      end
      2'd2: begin
        lane_byte          = pal_word[15:8];
        pal_merged[15:8]   = wdata_q;
      end
      default: begin
        lane_byte          = pal_word[7:0];
        pal_merged[7:0]    = wdata_q;
      end
    endcase
  end

  always_comb begin
    rd             = '0;
    ptr_next       = ptr;
    low_byte_next  = low_byte;
    pending_next   = pending;
    pal_sel_next   = pal_sel;
    ctrl_byte_next = ctrl_byte;
    vblank_next    = vblank;
    ready_next     = ready;
    vram_we        = 1'b0;
    pal_we         = 1'b0;
    scroll_we      = 1'b0;
    bank_we        = 1'b0;
    case (op_q)
      OP_READ: begin
        case (port_q) inside
          PORT_STATUS: begin
            rd         = {6'b0, ready, vblank};
            ready_next = 1'b0;
          end
          PORT_DATA: begin
            rd       = vram_q;
            ptr_next = 16'(ptr + 16'd1);
          end
          PORT_PAL_IDX:              rd = pal_sel;
          [PORT_PAL_R:PORT_PAL_A]:   rd = pal_in_range ? lane_byte : 8'd0;
          [PORT_SCROLL0:PORT_SCROLL3]: rd = scroll[port_q[1:0]];
          PORT_BANK0, PORT_BANK1:    rd = {7'b0, bank[port_q[0]]};
          default: ;
        endcase
      end
      OP_WRITE: begin
        case (port_q) inside
          PORT_CTRL: begin
            ctrl_byte_next = wdata_q;
            if (!pending) begin
              low_byte_next = wdata_q;
              pending_next  = 1'b1;
            end else begin
              ptr_next     = {wdata_q, low_byte};
              pending_next = 1'b0;
            end
          end
          PORT_DATA: begin
            vram_we  = 1'b1;
            ptr_next = 16'(ptr + 16'd1);
          end
          PORT_PAL_IDX:                pal_sel_next = wdata_q;
          [PORT_PAL_R:PORT_PAL_A]:     pal_we = pal_in_range;
          [PORT_SCROLL0:PORT_SCROLL3]: scroll_we = 1'b1;
          PORT_BANK0, PORT_BANK1:      bank_we = 1'b1;
          default: ;
        endcase
      end
      OP_TICK: begin
        if (line_q == 10'd0) begin
          vblank_next = 1'b0;
        end else if (line_q >= vblank_line) begin
          vblank_next = 1'b1;
        end
        if (line_q == ready_line) ready_next = 1'b1;
      end
      default: ;
    endcase
  end

  // VRAM: clearing sweep after reset, registered read on accept
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      vram[clear_addr] <= 8'd0;
    end else if (cmd.exec && vram_we) begin
      vram[vram_addr] <= wdata_q;
    end
    if (cmd.accept) vram_q <= vram[vram_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && pal_we) pal_mem[pal_idx] <= pal_merged;
    if (cmd.accept) pal_q <= pal_mem[pal_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear) begin
      clear_addr <= VRAM_ADDR_BITS'(clear_addr + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pal_valid   <= '0;
      ptr         <= '0;
      low_byte    <= '0;
      pending     <= 1'b0;
      pal_sel     <= '0;
      ctrl_byte   <= '0;
      scroll      <= '{default: '0};
      bank        <= '0;
      vblank      <= 1'b0;
      ready       <= 1'b0;
      vblank_line <= VBLANK_LINE_RESET;
      ready_line  <= READY_LINE_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_VBLANK_LINE) vblank_line <= cfg_data;
        if (cfg_index == CFG_READY_LINE)  ready_line  <= cfg_data;
      end
      if (cmd.accept) pal_vq <= pal_valid[pal_idx];
      if (cmd.exec) begin
        ptr       <= ptr_next;
        low_byte  <= low_byte_next;
        pending   <= pending_next;
        pal_sel   <= pal_sel_next;
        ctrl_byte <= ctrl_byte_next;
        vblank    <= vblank_next;
        ready     <= ready_next;
        if (pal_we)    pal_valid[pal_idx]  <= 1'b1;
        if (scroll_we) scroll[port_q[1:0]] <= wdata_q;
        if (bank_we)   bank[port_q[0]]     <= wdata_q[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q    <= opcode;
      port_q  <= port;
      wdata_q <= write_data;
      line_q  <= scanline;
    end
    if (cmd.exec) begin
      read_data     <= rd;
      cur_pointer   <= ptr_next;
      control_value <= ctrl_byte_next;
      frame_done    <= ready_next;
    end
  end

endmodule

/* rtl/video_port_register_interface.sv */
// channel  dir  fields                                          request when
// item     in   opcode, port, write_data, scanline              valid & ready
// result   out  read_data, cur_pointer, control_value,         valid & ready
//               frame_done
// cfg      in   cfg_index, cfg_data                             cfg_we
//
// The accept cycle loads the registered VRAM and palette reads, the next cycle
// writes back and loads the result register; no request is taken in that cycle.
// A new request is taken while a result waits, as long as it leaves that cycle.
// After rst a clearing sweep zeroes all 2**VRAM_ADDR_BITS VRAM addresses
// (65536 by default); no request is taken meanwhile, cfg writes still are.
// A stalled result holds the block at its next request.
module video_port_register_interface #(
  parameter int VRAM_ADDR_BITS  = vpri_pkg::VPRI_VRAM_ADDR_BITS,
  parameter int PALETTE_ENTRIES = vpri_pkg::VPRI_PALETTE_ENTRIES
) (
  input  logic                                clk,
  input  logic                                rst,
  vpri_item_if.sink                           item,
  vpri_result_if.source                       result,
  input  logic                                cfg_we,
  input  logic [vpri_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [vpri_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import vpri_pkg::*;

  cmd_t    cmd;
  status_t status;

  vpri_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .status     (status),
    .cmd        (cmd)
  );

  vpri_datapath #(
    .VRAM_ADDR_BITS  (VRAM_ADDR_BITS),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .opcode        (item.opcode),
    .port          (item.port),
    .write_data    (item.write_data),
    .scanline      (item.scanline),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .read_data     (result.read_data),
    .cur_pointer   (result.cur_pointer),
    .control_value (result.control_value),
    .frame_done    (result.frame_done)
  );

endmodule
